// ===== design/qtg_pkg.sv =====
// ----------------------------------------------------------------------------
// qtg_pkg: shared types and constants for the quintic trajectory generator
// Beat payloads, coefficient memory port structs and fixed arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package qtg_pkg;

    // Width of the signed working word for Horner sums and numerators.
    localparam int WIDE_W = 232;
    // Width of the divider magnitude path; numerators stay below 2^164.
    localparam int DIV_W = 168;
    localparam int COEFS = 6;

    localparam logic [31:0] MIN_DURATION = 32'd66;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [2:0] COEF_A0 = 3'd0;
    localparam logic [2:0] COEF_A1 = 3'd1;
    localparam logic [2:0] COEF_A2 = 3'd2;
    localparam logic [2:0] COEF_A3 = 3'd3;
    localparam logic [2:0] COEF_A4 = 3'd4;
    localparam logic [2:0] COEF_A5 = 3'd5;

    localparam logic [1:0] DERIV_POS = 2'd0;
    localparam logic [1:0] DERIV_VEL = 2'd1;
    localparam logic [1:0] DERIV_ACC = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic [2:0]         joint;
        logic signed [31:0] start_position;
        logic signed [31:0] start_velocity;
        logic signed [31:0] start_acceleration;
        logic signed [31:0] goal_position;
        logic signed [31:0] goal_velocity;
        logic signed [31:0] goal_acceleration;
        logic [31:0]        load_duration;
        logic signed [31:0] sample_time;
    } qtg_req_t;

    typedef struct packed {
        logic [2:0]         joint_index;
        logic signed [31:0] out_position;
        logic signed [31:0] out_velocity;
        logic signed [31:0] out_acceleration;
        logic               is_ready;
        logic               last_joint;
    } qtg_rsp_t;

    typedef struct packed {
        logic        en;
        logic [2:0]  joint;
        logic [2:0]  coef;
        logic [63:0] data;
    } qtg_mem_wr_t;

    typedef struct packed {
        logic       en;
        logic [2:0] joint;
        logic [2:0] coef;
    } qtg_mem_rd_t;

endpackage

`default_nettype wire

// ===== design/qtg_coef_mem.sv =====
// ----------------------------------------------------------------------------
// qtg_coef_mem: coefficient memory
// One write and one registered read port; rows never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_coef_mem import qtg_pkg::*; #(
    parameter int JOINTS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  qtg_mem_wr_t wr,
    input  qtg_mem_rd_t rd,
    output logic [63:0] rd_data
);

    localparam int DEPTH = JOINTS * COEFS;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    logic [63:0]       mem [DEPTH];
    logic [63:0]       q_reg;
    logic [JOINTS-1:0] vld_reg;
    logic              rvld_reg;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [JW-1:0]     wr_row;
    logic [JW-1:0]     rd_row;

    assign wr_addr = AW'(32'(wr.joint) * COEFS + 32'(wr.coef));
    assign rd_addr = AW'(32'(rd.joint) * COEFS + 32'(rd.coef));
    assign wr_row  = JW'(wr.joint);
    assign rd_row  = JW'(rd.joint);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd.en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // A row turns valid with its last coefficient; all six are written by then.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr.coef == COEF_A5)
            begin
                vld_reg[wr_row] <= 1'b1;
            end
            if (rd.en)
            begin
                rvld_reg <= vld_reg[rd_row];
            end
        end
    end

    assign rd_data = rvld_reg ? q_reg : 64'd0;

endmodule

`default_nettype wire

// ===== design/qtg_mul.sv =====
// ----------------------------------------------------------------------------
// qtg_mul: shift-add multiply-accumulate
// p = a * b + c over the wide signed word, one bit of b per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_mul import qtg_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [WIDE_W-1:0] a,
    input  logic [31:0]              b,
    input  logic signed [WIDE_W-1:0] c,
    output logic                     busy,
    output logic                     done,
    output logic signed [WIDE_W-1:0] p
);

    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [WIDE_W-1:0] mc_reg;
    logic [31:0]              mp_reg;
    logic                     busy_reg;
    logic                     done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            mc_reg   <= '0;
            mp_reg   <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (mp_reg[31:1] == 31'd0);
            if (start)
            begin
                acc_reg  <= c;
                mc_reg   <= a;
                mp_reg   <= b;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (mp_reg[0])
                begin
                    acc_reg <= acc_reg + mc_reg;
                end
                mc_reg <= mc_reg <<< 1;
                mp_reg <= mp_reg >> 1;
                // stop once no multiplier bits remain
                if (mp_reg[31:1] == 31'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

// ===== design/qtg_div.sv =====
// ----------------------------------------------------------------------------
// qtg_div: restoring divider for coefficient scaling
// Signed numerator over positive denominator, rounded to nearest and
// saturated to a signed 64-bit Q32.32 value.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_div import qtg_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [WIDE_W-1:0] num,
    input  logic signed [WIDE_W-1:0] den,
    output logic                     busy,
    output logic                     done,
    output logic [63:0]              q
);

    localparam int CW = $clog2(DIV_W);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} div_state_t;

    div_state_t        state_reg;
    logic              neg_reg;
    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [CW-1:0]     cnt_reg;
    logic [63:0]       q_reg;
    logic              done_reg;

    logic [WIDE_W-1:0] mag;
    logic [DIV_W:0]    rem_sh;
    logic              ge;
    logic              rup;
    logic [DIV_W-1:0]  qr;
    logic [63:0]       q_sat;

    always_comb
    begin
        mag    = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
        rem_sh = {rem_reg, num_reg[DIV_W-1]};
        ge     = rem_sh >= {1'b0, den_reg};
        rup    = {rem_reg, 1'b0} >= {1'b0, den_reg};
        qr     = quo_reg + DIV_W'(rup);
        if (neg_reg)
        begin
            q_sat = (qr > DIV_W'(64'h8000_0000_0000_0000)) ?
                    64'h8000_0000_0000_0000 : (~qr[63:0]) + 64'd1;
        end
        else
        begin
            q_sat = (qr >= DIV_W'(64'h8000_0000_0000_0000)) ?
                    64'h7FFF_FFFF_FFFF_FFFF : qr[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            neg_reg   <= 1'b0;
            num_reg   <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            q_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == D_FIN);
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= num[WIDE_W-1];
                        num_reg   <= mag[DIV_W-1:0];
                        den_reg   <= den[DIV_W-1:0];
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= CW'(DIV_W - 1);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? DIV_W'(rem_sh - {1'b0, den_reg}) : DIV_W'(rem_sh);
                    num_reg <= num_reg << 1;
                    quo_reg <= {quo_reg[DIV_W-2:0], ge};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    q_reg     <= q_sat;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != D_IDLE);
    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

// ===== design/quintic_trajectory_generator_top.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_generator_top: quintic trajectory generator
// Loads per-joint quintic coefficients and samples position, velocity and
// acceleration of all joints at a clamped time.
//
//   channel | signals                     | direction | beat
//   req     | req_valid, req_ready, req   | in        | one load or sample
//   rsp     | rsp_valid, rsp_ready, rsp   | out       | one joint result
//
// A load is paced by the bit-serial multiplier and the 168-step divider.
// A sample is paced per joint by Horner steps through the one shared multiplier;
// small times finish each multiply early.
// Before any load a sample skips the memory and emits zero results directly.
// Reset clears the valid bit of every coefficient row at once.
// A stalled rsp holds the sequencer; req is taken only between items.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_trajectory_generator_top import qtg_pkg::*; #(
    parameter int JOINTS = 6
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  qtg_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output qtg_rsp_t rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_LOW,
        S_LD_DGO,
        S_LD_DWT,
        S_LD_H1GO,
        S_LD_H1WT,
        S_LD_H2GO,
        S_LD_H2WT,
        S_LD_DVGO,
        S_LD_DVWT,
        S_SM_RD,
        S_SM_DAT,
        S_SM_MWT,
        S_SM_EMIT
    } state_t;

    localparam logic [2:0] LAST_JOINT = 3'(JOINTS - 1);

    state_t                   state_reg;
    qtg_req_t                 req_reg;
    logic [31:0]              tt_reg;
    logic [31:0]              t_reg;
    logic [31:0]              dur_reg;
    logic                     ready_reg;
    logic [2:0]               k_reg;
    logic [2:0]               n_reg;
    logic [1:0]               d_reg;
    logic [2:0]               j_reg;
    logic [1:0]               dleft_reg;
    logic signed [WIDE_W-1:0] den_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic [31:0]              pos_reg;
    logic [31:0]              vel_reg;
    logic [31:0]              accel_reg;
    qtg_rsp_t                 rsp_reg;
    logic                     rsp_valid_reg;

    logic                     mul_start;
    logic signed [WIDE_W-1:0] mul_a;
    logic [31:0]              mul_b;
    logic signed [WIDE_W-1:0] mul_c;
    logic                     mul_busy;
    logic                     mul_done;
    logic signed [WIDE_W-1:0] mul_p;
    logic                     div_start;
    logic signed [WIDE_W-1:0] div_num;
    logic                     div_busy;
    logic                     div_done;
    logic [63:0]              div_q;
    qtg_mem_wr_t              mem_wr;
    qtg_mem_rd_t              mem_rd;
    logic [63:0]              rd_data;

    logic                     joint_ok;
    logic [31:0]              tt_in;
    logic [31:0]              t_in;
    logic signed [39:0]       e_p0, e_v0, e_a0, e_pf, e_vf, e_af, dp;
    logic signed [39:0]       xs, ys, zs;
    logic [63:0]              low_coef;
    logic [4:0]               fac;
    logic signed [69:0]       gm;
    logic [6:0]               gsh;
    logic signed [WIDE_W-1:0] g_term;
    logic [31:0]              rnd;

    function automatic logic [31:0] round_q16(input logic signed [WIDE_W-1:0] h,
                                              input logic [1:0] d);
        logic [WIDE_W-1:0] mag;
        logic [WIDE_W-1:0] half;
        logic [WIDE_W-1:0] qq;
        logic [6:0]        sh;
        sh   = 7'd96 - 7'({d, 4'b0});
        mag  = h[WIDE_W-1] ? WIDE_W'(-h) : WIDE_W'(h);
        half = WIDE_W'(1) << (sh - 7'd1);
        qq   = (mag + half) >> sh;
        if (h[WIDE_W-1])
        begin
            return (qq > WIDE_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (~qq[31:0]) + 32'd1;
        end
        return (qq >= WIDE_W'(33'h0_8000_0000)) ? 32'h7FFF_FFFF : qq[31:0];
    endfunction

    // Request decode
    always_comb
    begin
        joint_ok = 32'(req.joint) < JOINTS;
        tt_in    = (req.load_duration < MIN_DURATION) ? MIN_DURATION : req.load_duration;
        if (req.sample_time < 0)
        begin
            t_in = 32'd0;
        end
        else if (32'(req.sample_time) > dur_reg)
        begin
            t_in = dur_reg;
        end
        else
        begin
            t_in = 32'(req.sample_time);
        end
    end

    // Boundary terms of the high coefficients
    always_comb
    begin
        e_p0 = 40'(req_reg.start_position);
        e_v0 = 40'(req_reg.start_velocity);
        e_a0 = 40'(req_reg.start_acceleration);
        e_pf = 40'(req_reg.goal_position);
        e_vf = 40'(req_reg.goal_velocity);
        e_af = 40'(req_reg.goal_acceleration);
        dp   = e_pf - e_p0;
        case (n_reg)
            COEF_A3:
            begin
                xs = dp * 40'sd20;
                ys = -(e_vf * 40'sd8 + e_v0 * 40'sd12);
                zs = e_af - e_a0 * 40'sd3;
            end
            COEF_A4:
            begin
                xs = -(dp * 40'sd30);
                ys = e_vf * 40'sd14 + e_v0 * 40'sd16;
                zs = e_a0 * 40'sd3 - e_af * 40'sd2;
            end
            default:
            begin
                xs = dp * 40'sd12;
                ys = -(e_vf * 40'sd6 + e_v0 * 40'sd6);
                zs = e_af - e_a0;
            end
        endcase
        case (k_reg)
            COEF_A0: low_coef = {{16{req_reg.start_position[31]}}, req_reg.start_position, 16'h0};
            COEF_A1: low_coef = {{16{req_reg.start_velocity[31]}}, req_reg.start_velocity, 16'h0};
            default: low_coef = {{17{req_reg.start_acceleration[31]}},
                                 req_reg.start_acceleration, 15'h0};
        endcase
    end

    // Horner addend: coefficient times derivative factor, aligned by its power
    always_comb
    begin
        case (d_reg)
            DERIV_POS: fac = 5'd1;
            DERIV_VEL: fac = {2'b0, k_reg};
            default:   fac = 5'({2'b0, k_reg} * ({2'b0, k_reg} - 5'd1));
        endcase
        gm     = 70'($signed(rd_data)) * 70'($signed({1'b0, fac}));
        gsh    = {3'(COEF_A5 - k_reg), 4'b0};
        g_term = WIDE_W'(gm) <<< gsh;
        rnd    = round_q16(mul_p, d_reg);
    end

    // Unit and memory control
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = acc_reg;
        mul_b     = tt_reg;
        mul_c     = '0;
        case (state_reg)
            S_LD_DGO:
            begin
                mul_start = 1'b1;
                mul_a     = den_reg;
            end
            S_LD_H1GO:
            begin
                mul_start = 1'b1;
                mul_a     = WIDE_W'(zs);
                mul_c     = WIDE_W'(ys) <<< 16;
            end
            S_LD_H2GO:
            begin
                mul_start = 1'b1;
                mul_c     = WIDE_W'(xs) <<< 32;
            end
            S_SM_DAT:
            begin
                mul_start = (k_reg != COEF_A5);
                mul_b     = t_reg;
                mul_c     = g_term;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase

        div_start = (state_reg == S_LD_DVGO);
        case (n_reg)
            COEF_A3: div_num = acc_reg <<< 32;
            COEF_A4: div_num = acc_reg <<< 48;
            default: div_num = acc_reg <<< 64;
        endcase

        mem_wr.en    = (state_reg == S_LD_LOW) || (state_reg == S_LD_DVWT && div_done);
        mem_wr.joint = req_reg.joint;
        mem_wr.coef  = (state_reg == S_LD_LOW) ? k_reg : n_reg;
        mem_wr.data  = (state_reg == S_LD_LOW) ? low_coef : div_q;

        mem_rd.en    = (state_reg == S_SM_RD);
        mem_rd.joint = j_reg;
        mem_rd.coef  = k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            tt_reg        <= MIN_DURATION;
            t_reg         <= '0;
            dur_reg       <= MIN_DURATION;
            ready_reg     <= 1'b0;
            k_reg         <= COEF_A0;
            n_reg         <= COEF_A3;
            d_reg         <= DERIV_POS;
            j_reg         <= '0;
            dleft_reg     <= '0;
            den_reg       <= '0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            accel_reg     <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // the emit state owns the valid flag while it runs
            if (rsp_valid_reg && rsp_ready && state_reg != S_SM_EMIT)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg <= req;
                        if (req.req_type == REQ_LOAD)
                        begin
                            // drop loads aimed past the last joint
                            if (joint_ok)
                            begin
                                tt_reg    <= tt_in;
                                k_reg     <= COEF_A0;
                                state_reg <= S_LD_LOW;
                            end
                        end
                        else
                        begin
                            t_reg     <= t_in;
                            j_reg     <= '0;
                            d_reg     <= DERIV_POS;
                            k_reg     <= COEF_A5;
                            pos_reg   <= '0;
                            vel_reg   <= '0;
                            accel_reg <= '0;
                            state_reg <= ready_reg ? S_SM_RD : S_SM_EMIT;
                        end
                    end
                end
                S_LD_LOW:
                begin
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == COEF_A2)
                    begin
                        den_reg   <= WIDE_W'({tt_reg, 1'b0});
                        dleft_reg <= 2'd2;
                        n_reg     <= COEF_A3;
                        state_reg <= S_LD_DGO;
                    end
                end
                S_LD_DGO:
                begin
                    state_reg <= S_LD_DWT;
                end
                S_LD_DWT:
                begin
                    if (mul_done)
                    begin
                        den_reg <= mul_p;
                        if (dleft_reg == 2'd1)
                        begin
                            state_reg <= S_LD_H1GO;
                        end
                        else
                        begin
                            dleft_reg <= dleft_reg - 2'd1;
                            state_reg <= S_LD_DGO;
                        end
                    end
                end
                S_LD_H1GO:
                begin
                    state_reg <= S_LD_H1WT;
                end
                S_LD_H1WT:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= mul_p;
                        state_reg <= S_LD_H2GO;
                    end
                end
                S_LD_H2GO:
                begin
                    state_reg <= S_LD_H2WT;
                end
                S_LD_H2WT:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= mul_p;
                        state_reg <= S_LD_DVGO;
                    end
                end
                S_LD_DVGO:
                begin
                    state_reg <= S_LD_DVWT;
                end
                S_LD_DVWT:
                begin
                    if (div_done)
                    begin
                        if (n_reg == COEF_A5)
                        begin
                            dur_reg   <= tt_reg;
                            ready_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            n_reg     <= n_reg + 3'd1;
                            dleft_reg <= 2'd1;
                            state_reg <= S_LD_DGO;
                        end
                    end
                end
                S_SM_RD:
                begin
                    state_reg <= S_SM_DAT;
                end
                S_SM_DAT:
                begin
                    if (k_reg == COEF_A5)
                    begin
                        acc_reg   <= g_term;
                        k_reg     <= k_reg - 3'd1;
                        state_reg <= S_SM_RD;
                    end
                    else
                    begin
                        state_reg <= S_SM_MWT;
                    end
                end
                S_SM_MWT:
                begin
                    if (mul_done)
                    begin
                        acc_reg <= mul_p;
                        if (k_reg == {1'b0, d_reg})
                        begin
                            case (d_reg)
                                DERIV_POS: pos_reg   <= rnd;
                                DERIV_VEL: vel_reg   <= rnd;
                                default:   accel_reg <= rnd;
                            endcase
                            if (d_reg == DERIV_ACC)
                            begin
                                state_reg <= S_SM_EMIT;
                            end
                            else
                            begin
                                d_reg     <= d_reg + 2'd1;
                                k_reg     <= COEF_A5;
                                state_reg <= S_SM_RD;
                            end
                        end
                        else
                        begin
                            k_reg     <= k_reg - 3'd1;
                            state_reg <= S_SM_RD;
                        end
                    end
                end
                S_SM_EMIT:
                begin
                    // hold until the output register frees up
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg            <= 1'b1;
                        rsp_reg.joint_index      <= j_reg;
                        rsp_reg.out_position     <= pos_reg;
                        rsp_reg.out_velocity     <= vel_reg;
                        rsp_reg.out_acceleration <= accel_reg;
                        rsp_reg.is_ready         <= ready_reg;
                        rsp_reg.last_joint       <= (j_reg == LAST_JOINT);
                        if (j_reg == LAST_JOINT)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 3'd1;
                            d_reg     <= DERIV_POS;
                            k_reg     <= COEF_A5;
                            state_reg <= ready_reg ? S_SM_RD : S_SM_EMIT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    qtg_coef_mem #(
        .JOINTS (JOINTS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

    qtg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .c     (mul_c),
        .busy  (mul_busy),
        .done  (mul_done),
        .p     (mul_p)
    );

    qtg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .q     (div_q)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_last_joint: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last_joint |-> rsp.joint_index == LAST_JOINT)
        else $error("last_joint flagged on a joint other than the last");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_ready |->
            rsp.out_position == 0 && rsp.out_velocity == 0 && rsp.out_acceleration == 0)
        else $error("nonzero result before any load");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    a_sample_holds: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.req_type == REQ_SAMPLE |=> !req_ready)
        else $error("request taken while a sample is in flight");

endmodule

`default_nettype wire

// ===== bench/qtg_checker.sv =====
// ----------------------------------------------------------------------------
// qtg_checker: scoreboard for the quintic trajectory generator
// Watches the req and rsp channels. On every accepted load of a joint in range
// it rebuilds the quintic coefficients of that joint. On every accepted sample it
// evaluates position, velocity and acceleration of all joints with wide exact
// arithmetic. It then compares each rsp beat with the oldest predicted result.
// ----------------------------------------------------------------------------
module qtg_checker import qtg_pkg::*; #(
    parameter int JOINTS = 6
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  qtg_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  qtg_rsp_t rsp,
    output int       mismatch_count,
    output int       pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [255:0] wide_t;

    logic [63:0] coef_mem [JOINTS][COEFS];
    logic [31:0] duration;
    logic        loaded;
    qtg_rsp_t    expected_results[$];

    assign pending_count = expected_results.size();

    // Signed numerator over positive denominator, rounded half away from zero,
    // saturated to a signed word of the given width.
    function automatic logic [63:0] round_div(wide_t num, wide_t den, int bits);
        logic  neg;
        wide_t mag;
        wide_t q;
        wide_t r;
        logic [63:0] lim;
        logic [63:0] m;
        logic  over;
        neg = num[255];
        mag = neg ? (~num + 256'd1) : num;
        q = mag / den;
        r = mag - q * den;
        if ((r << 1) >= den)
            q = q + 256'd1;
        lim = 64'd1 << (bits - 1);
        m = q[63:0];
        over = |q[255:64];
        if (neg)
            return (over || m > lim) ? (64'd0 - lim) : (64'd0 - m);
        return (over || m >= lim) ? (lim - 64'd1) : m;
    endfunction

    function automatic wide_t sext64(logic [63:0] v);
        return {{192{v[63]}}, v};
    endfunction

    function automatic wide_t sext32(logic [31:0] v);
        return {{224{v[31]}}, v};
    endfunction

    task automatic load_joint(qtg_req_t it);
        wide_t p0, v0, a0, pf, vf, af, dp, tt;
        wide_t xs, ys, zs, num, den;
        int n;
        p0 = sext32(it.start_position);
        v0 = sext32(it.start_velocity);
        a0 = sext32(it.start_acceleration);
        pf = sext32(it.goal_position);
        vf = sext32(it.goal_velocity);
        af = sext32(it.goal_acceleration);
        tt = {224'd0, (it.load_duration < MIN_DURATION) ? MIN_DURATION : it.load_duration};
        dp = pf - p0;
        coef_mem[it.joint][COEF_A0] = p0[63:0] << 16;
        coef_mem[it.joint][COEF_A1] = v0[63:0] << 16;
        coef_mem[it.joint][COEF_A2] = a0[63:0] << 15;
        for (n = 3; n <= 5; n++)
        begin
            case (n)
                3:
                begin
                    xs = 256'd20 * dp;
                    ys = 256'd0 - (256'd8 * vf + 256'd12 * v0);
                    zs = 256'd0 - (256'd3 * a0 - af);
                end
                4:
                begin
                    xs = 256'd0 - 256'd30 * dp;
                    ys = 256'd14 * vf + 256'd16 * v0;
                    zs = 256'd3 * a0 - 256'd2 * af;
                end
                default:
                begin
                    xs = 256'd12 * dp;
                    ys = 256'd0 - (256'd6 * vf + 256'd6 * v0);
                    zs = af - a0;
                end
            endcase
            num = (xs << 32) + ((ys * tt) << 16) + zs * tt * tt;
            num = num << (16 * n - 16);
            den = 256'd2;
            repeat (n) den = den * tt;
            coef_mem[it.joint][n] = round_div(num, den, 64);
        end
        duration = tt[31:0];
        loaded = 1'b1;
    endtask

    function automatic logic [31:0] eval_deriv(int j, logic [31:0] t, int d);
        wide_t sum;
        wide_t term;
        wide_t tw;
        logic [63:0] res;
        int k;
        sum = '0;
        tw = {224'd0, t};
        for (k = d; k <= 5; k++)
        begin
            term = sext64(coef_mem[j][k]);
            if (d == 1)
                term = term * k;
            else if (d == 2)
                term = term * (k * (k - 1));
            repeat (k - d) term = term * tw;
            sum = sum + (term << (16 * (5 - k)));
        end
        res = round_div(sum, 256'd1 << (96 - 16 * d), 32);
        return res[31:0];
    endfunction

    task automatic predict_sample(qtg_req_t it);
        logic [31:0] t;
        qtg_rsp_t r;
        int j;
        if (it.sample_time[31])
            t = '0;
        else if (it.sample_time > duration)
            t = duration;
        else
            t = it.sample_time;
        for (j = 0; j < JOINTS; j++)
        begin
            r.joint_index      = j[2:0];
            r.out_position     = loaded ? eval_deriv(j, t, DERIV_POS) : '0;
            r.out_velocity     = loaded ? eval_deriv(j, t, DERIV_VEL) : '0;
            r.out_acceleration = loaded ? eval_deriv(j, t, DERIV_ACC) : '0;
            r.is_ready         = loaded;
            r.last_joint       = (j == JOINTS - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic report(string what, qtg_rsp_t e, qtg_rsp_t a);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t rsp %s: exp j=%0d p=%h v=%h a=%h rdy=%b last=%b / got j=%0d p=%h v=%h a=%h rdy=%b last=%b",
                     $realtime, what, e.joint_index, e.out_position, e.out_velocity,
                     e.out_acceleration, e.is_ready, e.last_joint, a.joint_index,
                     a.out_position, a.out_velocity, a.out_acceleration, a.is_ready,
                     a.last_joint);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < JOINTS; j++)
                for (int k = 0; k < COEFS; k++)
                    coef_mem[j][k] = '0;
            duration = MIN_DURATION;
            loaded = 1'b0;
            mismatch_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                    report("unexpected", '0, rsp);
                else if (expected_results[0] !== rsp)
                    report("mismatch", expected_results.pop_front(), rsp);
                else
                    void'(expected_results.pop_front());
            end
            if (req_valid && req_ready)
            begin
                if (req.req_type == REQ_SAMPLE)
                    predict_sample(req);
                else if (req.joint < JOINTS)
                    load_joint(req);
            end
        end
    end
endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the quintic trajectory generator
// Drives directed and random load and sample beats under several idle and
// stall mixes; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
    import qtg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int JOINTS = 6;
    localparam int CYCLE_LIMIT = 6000000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    qtg_req_t req;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    qtg_rsp_t rsp;
    int       mismatch_count;
    int       pending_count;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       cycles = 0;
    logic [31:0] cur_duration = MIN_DURATION;

    always #1 clk = ~clk;

    quintic_trajectory_generator_top #(.JOINTS(JOINTS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    qtg_checker #(.JOINTS(JOINTS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .mismatch_count(mismatch_count), .pending_count(pending_count)
    );

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(qtg_req_t it);
        req <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // drop valid after the last beat, let the checker see the final accept and wait until no result is pending
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
    endtask

    task automatic load_beat(logic [2:0] j, logic [31:0] p0, logic [31:0] v0,
                             logic [31:0] a0, logic [31:0] pf, logic [31:0] vf,
                             logic [31:0] af, logic [31:0] dur);
        qtg_req_t it;
        it = '{req_type: REQ_LOAD, joint: j, start_position: p0, start_velocity: v0,
               start_acceleration: a0, goal_position: pf, goal_velocity: vf,
               goal_acceleration: af, load_duration: dur, sample_time: $urandom};
        if (j < JOINTS)
            cur_duration = (dur < MIN_DURATION) ? MIN_DURATION : dur;
        send(it);
    endtask

    task automatic sample_beat(logic [31:0] t);
        qtg_req_t it;
        it = '{req_type: REQ_SAMPLE, joint: 3'($urandom), start_position: $urandom,
               start_velocity: $urandom, start_acceleration: $urandom,
               goal_position: $urandom, goal_velocity: $urandom,
               goal_acceleration: $urandom, load_duration: $urandom, sample_time: t};
        send(it);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            2: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_duration();
        case ($urandom_range(9))
            0: return $urandom_range(0, 65);
            1: return $urandom;
            default: return $urandom_range(66, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h8000_0000 | $urandom;
            2: return cur_duration + $urandom_range(1, 1000);
            3: return 32'd0;
            default: return $urandom_range(0, cur_duration);
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not ready yet: samples give zeros
        sample_beat(32'd0);
        sample_beat(32'h7FFF_FFFF);
        // out of range joints are dropped
        load_beat(3'd6, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000);
        load_beat(3'd7, 32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000);
        sample_beat(32'h0000_8000);
        // extremes, minimum duration raised
        load_beat(3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        sample_beat(32'd33);
        load_beat(3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        sample_beat(32'h7FFF_FFFF);
        load_beat(3'd2, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000,
                  32'h000A_0000, 32'h0, 32'h0, 32'h0002_0000);
        sample_beat(32'h8000_0000);
        sample_beat(32'h0001_0000);
        sample_beat(32'h0002_0000);
        sample_beat(32'h0003_0000);
        load_beat(3'd3, 0, 0, 0, 0, 0, 0, 32'd65);
        load_beat(3'd4, 32'hFFF0_0000, 32'h0010_0000, 32'h0, 32'h0010_0000,
                  32'hFFF0_0000, 32'h0001_0000, 32'h0000_4000);
        load_beat(3'd5, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F,
                  32'hEDCB_A987, 32'h0123_4567, 32'hF0F0_F0F0, 32'h0001_8000);
        sample_beat(32'd0);
        sample_beat(32'h0000_C000);
        sample_beat(32'h0001_8000);
        sample_beat(32'hFFFF_FFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            // hold until the block has drained before changing the mix
            drain();
            repeat (800) @(posedge clk);
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            for (int n = 0; n < 75; n++)
            begin
                if ($urandom_range(99) < 45)
                    load_beat(3'($urandom_range(0, 7)), rand_value(), rand_value(),
                              rand_value(), rand_value(), rand_value(), rand_value(),
                              rand_duration());
                else
                    sample_beat(rand_time());
            end
        end

        drain();
        repeat (3000) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/qtg_pkg.sv
design/qtg_coef_mem.sv
design/qtg_mul.sv
design/qtg_div.sv
design/quintic_trajectory_generator_top.sv
bench/qtg_checker.sv
bench/tb_top.sv
